@@ rtl/acp_pkg.sv @@
// Shared types and constants for the two-antenna Alamouti pair combiner.
`timescale 1ns / 1ps
`default_nettype none

package acp_pkg;

    // Fixed field widths.
    localparam int SAMPLE_WIDTH = 16;
    localparam int OUT_WIDTH    = 20;
    localparam int CFG_WIDTH    = 11;

    // Default subcarrier capacity handed to the top level.
    localparam int MAX_SUBCARRIERS_DEF = 1024;

    // Reset value of the vector length register.
    localparam logic [CFG_WIDTH-1:0] VECTOR_LENGTH_RESET = CFG_WIDTH'(64);

    // Internal arithmetic widths: exact product, pair sum, quad sum, pair total.
    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int PAIR_W = PROD_W + 1;
    localparam int QUAD_W = PROD_W + 2;
    localparam int ACC_W  = PROD_W + 4;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One subcarrier request.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] rx_a_re;
        logic signed [SAMPLE_WIDTH-1:0] rx_a_im;
        logic signed [SAMPLE_WIDTH-1:0] rx_b_re;
        logic signed [SAMPLE_WIDTH-1:0] rx_b_im;
        logic signed [SAMPLE_WIDTH-1:0] chan_zero_re;
        logic signed [SAMPLE_WIDTH-1:0] chan_zero_im;
        logic signed [SAMPLE_WIDTH-1:0] chan_one_re;
        logic signed [SAMPLE_WIDTH-1:0] chan_one_im;
        logic signed [SAMPLE_WIDTH-1:0] chan_two_re;
        logic signed [SAMPLE_WIDTH-1:0] chan_two_im;
        logic signed [SAMPLE_WIDTH-1:0] chan_three_re;
        logic signed [SAMPLE_WIDTH-1:0] chan_three_im;
    } in_item_t;

    // One result request.
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] symbol_re;
        logic signed [OUT_WIDTH-1:0] symbol_im;
        logic                        last_in_vector;
    } out_item_t;

    // Full-precision pair total as queued between front and back.
    typedef struct packed {
        logic signed [ACC_W-1:0] sum_re;
        logic signed [ACC_W-1:0] sum_im;
        logic                    last;
    } pair_sum_t;

endpackage

`default_nettype wire

@@ rtl/acp_front.sv @@
// Front end: accepts subcarriers, tracks the pair position and forms the pair sums.
`timescale 1ns / 1ps
`default_nettype none

module acp_front
    import acp_pkg::*;
#(
    parameter int MAX_SUBCARRIERS = MAX_SUBCARRIERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    input  in_item_t             in_data,
    output logic                 in_ready,
    output logic                 q_push,
    output pair_sum_t            q_push_data,
    input  logic                 q_pop
);

    // Position counter width: enough for the largest usable vector.
    localparam int POS_FULL = $clog2(MAX_SUBCARRIERS);
    localparam int POS_W    = (POS_FULL < 1) ? 1 :
                              ((POS_FULL < CFG_WIDTH) ? POS_FULL : CFG_WIDTH);
    localparam int unsigned CAP_EVEN = (MAX_SUBCARRIERS / 2) * 2;
    localparam int unsigned CAP_TOP  = (2 ** CFG_WIDTH) - 2;
    localparam int unsigned CAP_INT  = (CAP_EVEN > CAP_TOP) ? CAP_TOP : CAP_EVEN;
    localparam logic [CFG_WIDTH-1:0] CAP     = CFG_WIDTH'(CAP_INT);
    localparam logic [CFG_WIDTH-1:0] MIN_LEN = CFG_WIDTH'(2);

    logic [CFG_WIDTH-1:0] vector_length_reg;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [QCNT_W-1:0]    credits_reg, credits_next;

    logic [CFG_WIDTH-1:0] len_even, len_eff;
    logic [CFG_WIDTH:0]   pos_plus1;
    logic                 accept, odd_in, last_in;

    logic signed [SAMPLE_WIDTH-1:0] ha_re, ha_im, hb_re, hb_im;

    // Stage 1: exact products.
    logic                     s1_valid_reg, s1_odd_reg, s1_last_reg;
    logic signed [PROD_W-1:0] rr_a_reg, ii_a_reg, ri_a_reg, ir_a_reg;
    logic signed [PROD_W-1:0] rr_b_reg, ii_b_reg, ri_b_reg, ir_b_reg;

    // Stage 2: per-antenna sums.
    logic                     s2_valid_reg, s2_odd_reg, s2_last_reg;
    logic signed [PAIR_W-1:0] re_a_reg, im_a_reg, re_b_reg, im_b_reg;

    // Stage 3: subcarrier sums.
    logic                     s3_valid_reg, s3_odd_reg, s3_last_reg;
    logic signed [QUAD_W-1:0] sum_re_reg, sum_im_reg;

    // Even-subcarrier partial sum held for its odd partner.
    logic signed [QUAD_W-1:0] partial_re_reg, partial_im_reg;

    // Effective vector length: even, at least two, at most the capacity.
    always_comb
    begin
        len_even = {vector_length_reg[CFG_WIDTH-1:1], 1'b0};
        len_eff  = len_even;
        if (len_eff < MIN_LEN)
        begin
            len_eff = MIN_LEN;
        end
        if (len_eff > CAP)
        begin
            len_eff = CAP;
        end
    end

    // Room is reserved in the queue for every odd subcarrier in flight.
    assign in_ready  = (credits_reg < QCNT_W'(QUEUE_DEPTH));
    assign accept    = in_valid && in_ready;
    assign odd_in    = pos_reg[0];
    assign pos_plus1 = (CFG_WIDTH + 1)'(pos_reg) + (CFG_WIDTH + 1)'(1);
    assign last_in   = odd_in && (pos_plus1 >= {1'b0, len_eff});

    // Position update: wrap only after the odd member of a pair.
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (last_in)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_plus1[POS_W-1:0];
            end
        end
    end

    // Credit count: taken by an odd request, returned when the back pops.
    always_comb
    begin
        credits_next = credits_reg;
        if (accept && odd_in && !q_pop)
        begin
            credits_next = credits_reg + QCNT_W'(1);
        end
        else if (q_pop && !(accept && odd_in))
        begin
            credits_next = credits_reg - QCNT_W'(1);
        end
    end

    // Channel estimates for this member of the pair.
    always_comb
    begin
        if (odd_in)
        begin
            ha_re = in_data.chan_one_re;
            ha_im = in_data.chan_one_im;
            hb_re = in_data.chan_three_re;
            hb_im = in_data.chan_three_im;
        end
        else
        begin
            ha_re = in_data.chan_zero_re;
            ha_im = in_data.chan_zero_im;
            hb_re = in_data.chan_two_re;
            hb_im = in_data.chan_two_im;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= VECTOR_LENGTH_RESET;
            pos_reg           <= '0;
            credits_reg       <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vector_length_reg <= cfg_data;
            end
            pos_reg      <= pos_next;
            credits_reg  <= credits_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        s1_odd_reg  <= odd_in;
        s1_last_reg <= last_in;
        rr_a_reg    <= ha_re * in_data.rx_a_re;
        ii_a_reg    <= ha_im * in_data.rx_a_im;
        ri_a_reg    <= ha_re * in_data.rx_a_im;
        ir_a_reg    <= ha_im * in_data.rx_a_re;
        rr_b_reg    <= hb_re * in_data.rx_b_re;
        ii_b_reg    <= hb_im * in_data.rx_b_im;
        ri_b_reg    <= hb_re * in_data.rx_b_im;
        ir_b_reg    <= hb_im * in_data.rx_b_re;

        // The odd member uses h*conj(y), which flips the sign of the cross terms.
        s2_odd_reg  <= s1_odd_reg;
        s2_last_reg <= s1_last_reg;
        re_a_reg    <= PAIR_W'(rr_a_reg) + PAIR_W'(ii_a_reg);
        re_b_reg    <= PAIR_W'(rr_b_reg) + PAIR_W'(ii_b_reg);
        if (s1_odd_reg)
        begin
            im_a_reg <= PAIR_W'(ir_a_reg) - PAIR_W'(ri_a_reg);
            im_b_reg <= PAIR_W'(ir_b_reg) - PAIR_W'(ri_b_reg);
        end
        else
        begin
            im_a_reg <= PAIR_W'(ri_a_reg) - PAIR_W'(ir_a_reg);
            im_b_reg <= PAIR_W'(ri_b_reg) - PAIR_W'(ir_b_reg);
        end

        s3_odd_reg  <= s2_odd_reg;
        s3_last_reg <= s2_last_reg;
        sum_re_reg  <= QUAD_W'(re_a_reg) + QUAD_W'(re_b_reg);
        sum_im_reg  <= QUAD_W'(im_a_reg) + QUAD_W'(im_b_reg);

        if (s3_valid_reg && !s3_odd_reg)
        begin
            partial_re_reg <= sum_re_reg;
            partial_im_reg <= sum_im_reg;
        end
    end

    // The odd member completes the pair and is queued.
    assign q_push             = s3_valid_reg && s3_odd_reg;
    assign q_push_data.sum_re = ACC_W'(partial_re_reg) + ACC_W'(sum_re_reg);
    assign q_push_data.sum_im = ACC_W'(partial_im_reg) + ACC_W'(sum_im_reg);
    assign q_push_data.last   = s3_last_reg;

endmodule

`default_nettype wire

@@ rtl/acp_queue.sv @@
// Short queue of pair totals between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module acp_queue
    import acp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pair_sum_t push_data,
    input  logic      pop,
    output pair_sum_t pop_data,
    output logic      not_empty
);

    pair_sum_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointers and fill count; the front never pushes into a full queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/acp_back.sv @@
// Back end: rounds each pair total and emits the symbol request and the zero request.
`timescale 1ns / 1ps
`default_nettype none

module acp_back
    import acp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_not_empty,
    input  pair_sum_t q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [1:0] {
        SLOT_SYMBOL = 2'b01,
        SLOT_ZERO   = 2'b10
    } slot_t;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (SAMPLE_WIDTH - 2);
    localparam int SHIFT = SAMPLE_WIDTH - 1;

    slot_t     slot_reg, slot_next;
    logic      out_valid_reg, out_valid_next;
    logic      last_hold_reg, last_hold_next;
    out_item_t out_data_reg, out_data_next;
    logic      free;

    logic signed [ACC_W-1:0] biased_re, biased_im;

    // Round half up to fifteen fraction bits.
    assign biased_re = q_data.sum_re + ROUND_BIAS;
    assign biased_im = q_data.sum_im + ROUND_BIAS;

    assign free = !out_valid_reg || out_ready;

    // Output slot sequencing: symbol, then zero, then the next pair.
    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        last_hold_next = last_hold_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        if (free)
        begin
            case (slot_reg)
                SLOT_SYMBOL:
                begin
                    if (out_valid_reg)
                    begin
                        slot_next                    = SLOT_ZERO;
                        out_valid_next               = 1'b1;
                        out_data_next.symbol_re      = '0;
                        out_data_next.symbol_im      = '0;
                        out_data_next.last_in_vector = last_hold_reg;
                    end
                    else if (q_not_empty)
                    begin
                        q_pop                        = 1'b1;
                        out_valid_next               = 1'b1;
                        last_hold_next               = q_data.last;
                        out_data_next.symbol_re      = biased_re[SHIFT+OUT_WIDTH-1:SHIFT];
                        out_data_next.symbol_im      = biased_im[SHIFT+OUT_WIDTH-1:SHIFT];
                        out_data_next.last_in_vector = 1'b0;
                    end
                end
                SLOT_ZERO:
                begin
                    slot_next      = SLOT_SYMBOL;
                    out_valid_next = 1'b0;
                    if (q_not_empty)
                    begin
                        q_pop                        = 1'b1;
                        out_valid_next               = 1'b1;
                        last_hold_next               = q_data.last;
                        out_data_next.symbol_re      = biased_re[SHIFT+OUT_WIDTH-1:SHIFT];
                        out_data_next.symbol_im      = biased_im[SHIFT+OUT_WIDTH-1:SHIFT];
                        out_data_next.last_in_vector = 1'b0;
                    end
                end
                default:
                begin
                    slot_next      = SLOT_SYMBOL;
                    out_valid_next = 1'b0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_SYMBOL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        last_hold_reg <= last_hold_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/alamouti_pair_combiner_two_rx.sv @@
// Top level of the two-antenna Alamouti space-frequency pair combiner.
//
// Input channel (in_valid, in_ready, in_data): one request per subcarrier carrying
// both antenna samples and the four channel estimates. Subcarriers pair up as even
// then odd; an even request produces nothing, an odd one produces two output
// requests: the combined Q4.15 symbol, then a zero symbol that carries the
// end-of-vector flag when the pair closes the vector.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): the vector length, taken
// at any cycle; write it only while no request is in flight. Reset value is 64.
// Throughput: one subcarrier and one output per cycle while out_ready stays high.
// Path: after its odd subcarrier is accepted, the symbol passes the multiply stage,
// two add stages, the queue entry and the output register; the zero follows.
// A four-entry queue separates the arithmetic pipeline from the output register;
// when the receiver stalls, the queue fills and in_ready drops once every entry
// is reserved by an odd subcarrier in flight.
// Reset clears the pair position, the pipeline valids, the queue and the output.
`timescale 1ns / 1ps
`default_nettype none

module alamouti_pair_combiner_two_rx
    import acp_pkg::*;
#(
    parameter int MAX_SUBCARRIERS = MAX_SUBCARRIERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data
);

    logic      q_push, q_pop, q_not_empty;
    pair_sum_t q_push_data, q_pop_data;

    assign cfg_ready = 1'b1;

    // Front: pair tracking and arithmetic pipeline.
    acp_front #(
        .MAX_SUBCARRIERS (MAX_SUBCARRIERS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .in_ready    (in_ready),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_pop       (q_pop)
    );

    // Queue of completed pair totals.
    acp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    // Back: rounding and output slots.
    acp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the two-antenna Alamouti pair combiner.
`timescale 1ns / 1ps

module tb_top;
    import acp_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_WIDTH-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;

    // Subcarriers waiting for the driver and symbols waiting for the block.
    in_item_t  pending_subcarriers[$];
    out_item_t expected_symbols[$];

    int  items_queued = 0;
    int  items_taken  = 0;
    int  mismatches   = 0;
    bit  in_took      = 1'b0;
    bit  cfg_took     = 1'b0;

    // Traffic shaping knobs set per phase.
    bit  bursty       = 1'b0;
    int  stall_pct    = 0;
    int  holds_wanted = 0;
    int  holds_done   = 0;

    // Predictor state: register copy, pair position and even-subcarrier sum.
    logic [CFG_WIDTH-1:0] vec_len_reg = VECTOR_LENGTH_RESET;
    logic [CFG_WIDTH-1:0] pair_pos = '0;
    longint               even_sum_re = 0;
    longint               even_sum_im = 0;

    alamouti_pair_combiner_two_rx DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Fold one accepted subcarrier into the pair sum and queue the symbols it yields.
    task automatic combine_subcarrier(input in_item_t s);
        longint    y0r, y0i, y1r, y1i, h0r, h0i, h1r, h1i, h2r, h2i, h3r, h3i;
        longint    sr, si, rr, ri;
        int        len;
        bit        wrap;
        out_item_t r;
        y0r = $signed(s.rx_a_re);       y0i = $signed(s.rx_a_im);
        y1r = $signed(s.rx_b_re);       y1i = $signed(s.rx_b_im);
        h0r = $signed(s.chan_zero_re);  h0i = $signed(s.chan_zero_im);
        h1r = $signed(s.chan_one_re);   h1i = $signed(s.chan_one_im);
        h2r = $signed(s.chan_two_re);   h2i = $signed(s.chan_two_im);
        h3r = $signed(s.chan_three_re); h3i = $signed(s.chan_three_im);
        if (pair_pos[0] == 1'b0)
        begin
            even_sum_re = h0r * y0r + h0i * y0i + h2r * y1r + h2i * y1i;
            even_sum_im = h0r * y0i - h0i * y0r + h2r * y1i - h2i * y1r;
            pair_pos = pair_pos + 1'b1;
        end
        else
        begin
            sr = even_sum_re + h1r * y0r + h1i * y0i + h3r * y1r + h3i * y1i;
            si = even_sum_im + h1i * y0r - h1r * y0i + h3i * y1r - h3r * y1i;
            // Odd lengths round down; the length is clamped to 2..capacity.
            len = {vec_len_reg[CFG_WIDTH-1:1], 1'b0};
            if (len < 2)
                len = 2;
            if (len > MAX_SUBCARRIERS_DEF)
                len = MAX_SUBCARRIERS_DEF;
            wrap = (int'(pair_pos) + 1) >= len;
            // Round half up to 15 fraction bits.
            rr = (sr + 64'sd16384) >>> 15;
            ri = (si + 64'sd16384) >>> 15;
            r.symbol_re      = rr[OUT_WIDTH-1:0];
            r.symbol_im      = ri[OUT_WIDTH-1:0];
            r.last_in_vector = 1'b0;
            expected_symbols.push_back(r);
            r.symbol_re      = '0;
            r.symbol_im      = '0;
            r.last_in_vector = wrap;
            expected_symbols.push_back(r);
            even_sum_re = 0;
            even_sum_im = 0;
            pair_pos = wrap ? '0 : pair_pos + 1'b1;
        end
    endtask

    // Monitor: record handshakes, run the predictor and check every result.
    always @(posedge clk)
    begin
        out_item_t want;
        cfg_took <= cfg_valid && cfg_ready;
        in_took  <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                vec_len_reg = cfg_data;
            if (in_valid && in_ready)
            begin
                combine_subcarrier(in_data);
                items_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $error("result with nothing expected: re %0d im %0d last %0b",
                           out_data.symbol_re, out_data.symbol_im, out_data.last_in_vector);
                    mismatches++;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (out_data.symbol_re !== want.symbol_re)
                    begin
                        $error("symbol_re expected %0d actual %0d",
                               want.symbol_re, out_data.symbol_re);
                        mismatches++;
                    end
                    if (out_data.symbol_im !== want.symbol_im)
                    begin
                        $error("symbol_im expected %0d actual %0d",
                               want.symbol_im, out_data.symbol_im);
                        mismatches++;
                    end
                    if (out_data.last_in_vector !== want.last_in_vector)
                    begin
                        $error("last_in_vector expected %0b actual %0b",
                               want.last_in_vector, out_data.last_in_vector);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Driver: feeds subcarriers in bursts, separated by random gaps when bursty is set.
    always @(negedge clk)
    begin
        int gap_left;
        int burst_left;
        if (in_valid && !in_took)
        begin
            // Request still waiting for the block; hold it.
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (pending_subcarriers.size() > 0)
        begin
            in_data  <= pending_subcarriers.pop_front();
            in_valid <= 1'b1;
            if (burst_left > 1)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = bursty ? $urandom_range(1, 7) : 0;
            end
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: random stalls, plus long hold-offs on request.
    always @(negedge clk)
    begin
        int hold_left;
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (holds_done != holds_wanted)
        begin
            holds_done++;
            hold_left = 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Corner values of a Q0.15 field.
    function automatic logic [SAMPLE_WIDTH-1:0] corner_value();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    function automatic in_item_t make_subcarrier(bit corners);
        logic [12*SAMPLE_WIDTH-1:0] bits;
        for (int k = 0; k < 12; k++)
            bits[k*SAMPLE_WIDTH +: SAMPLE_WIDTH] =
                corners ? corner_value() : SAMPLE_WIDTH'($urandom);
        return in_item_t'(bits);
    endfunction

    // All samples set to y and all channel estimates set to h.
    function automatic in_item_t flat_subcarrier(logic [15:0] y, logic [15:0] h);
        in_item_t s;
        s.rx_a_re = y;       s.rx_a_im = y;       s.rx_b_re = y;       s.rx_b_im = y;
        s.chan_zero_re = h;  s.chan_zero_im = h;  s.chan_one_re = h;   s.chan_one_im = h;
        s.chan_two_re = h;   s.chan_two_im = h;   s.chan_three_re = h; s.chan_three_im = h;
        return s;
    endfunction

    task automatic queue_subcarrier(input in_item_t s);
        pending_subcarriers.push_back(s);
        items_queued++;
    endtask

    // Block until every queued subcarrier is taken and every symbol has arrived,
    // then let the pipeline settle in case the last subcarrier was an even one.
    task automatic wait_idle();
        @(negedge clk);
        while (items_taken != items_queued || expected_symbols.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_length(input logic [CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_took)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One phase: new vector length, traffic shape, then random subcarriers.
    task automatic run_phase(input logic [CFG_WIDTH-1:0] len, input int count,
                             input bit gaps, input int stall, input bit long_hold);
        write_length(len);
        bursty    = gaps;
        stall_pct = stall;
        if (long_hold)
            holds_wanted++;
        for (int k = 0; k < count; k++)
            queue_subcarrier(make_subcarrier($urandom_range(0, 4) == 0));
        wait_idle();
    endtask

    // Main sequence.
    initial
    begin
        in_item_t s;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pairs under the reset length.
        bursty    = 1'b0;
        stall_pct = 0;
        queue_subcarrier('0);
        queue_subcarrier('0);
        queue_subcarrier(flat_subcarrier(16'sh8000, 16'sh8000));
        queue_subcarrier(flat_subcarrier(16'sh8000, 16'sh8000));
        queue_subcarrier(flat_subcarrier(16'sh7FFF, 16'sh7FFF));
        queue_subcarrier(flat_subcarrier(16'sh7FFF, 16'sh7FFF));
        queue_subcarrier(flat_subcarrier(16'sh8000, 16'sh7FFF));
        queue_subcarrier(flat_subcarrier(16'sh8000, 16'sh7FFF));
        queue_subcarrier(flat_subcarrier(16'sh7FFF, 16'sh8000));
        queue_subcarrier(flat_subcarrier(16'sh8000, 16'sh7FFF));
        // Rounding ties: exactly half an LSB, positive then negative.
        s = '0;
        s.rx_a_re = 16'sh0001;
        s.chan_zero_re = 16'sh4000;
        queue_subcarrier(s);
        queue_subcarrier('0);
        s.chan_zero_re = 16'shC000;
        queue_subcarrier(s);
        queue_subcarrier('0);
        // Only the odd subcarrier contributes.
        queue_subcarrier('0);
        queue_subcarrier(flat_subcarrier(16'sh8000, 16'sh8000));
        for (int k = 0; k < 8; k++)
            queue_subcarrier(make_subcarrier(1'b1));
        wait_idle();

        // Length sweep: minimum, below minimum, odd values, capacity and beyond.
        run_phase(11'd2,    40, 1'b1, 30, 1'b0);
        run_phase(11'd0,    41, 1'b1, 50, 1'b0);
        run_phase(11'd1,    40, 1'b0,  0, 1'b0);
        run_phase(11'd3,    41, 1'b1, 70, 1'b0);
        run_phase(11'($urandom_range(4, 40)), 40, 1'b1, 20, 1'b0);
        run_phase(11'd7,    40, 1'b0, 10, 1'b0);
        run_phase(11'd1024, 500, 1'b0, 0, 1'b1);
        run_phase(11'd1025, 401, 1'b1, 30, 1'b0);
        run_phase(11'd2047, 200, 1'b1, 40, 1'b0);
        // Shrink well below the current position.
        run_phase(11'd6,    40, 1'b1, 30, 1'b1);
        run_phase(11'd64,   41, 1'b0, 60, 1'b0);

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
